// ===== hdl/iirdf1_pkg.sv =====
package iirdf1_pkg;

   // Data path sizing
   localparam int SAMPLE_BITS      = 16;
   localparam int COEFF_WIDTH      = 18;
   localparam int COEFF_FRAC_BITS  = 14;
   localparam int SAMPLE_FRAC_BITS = 0;
   localparam int FF_TAPS          = 3;
   localparam int FB_TAPS          = 2;

   // Register file
   localparam int NUM_REGS    = 5;
   localparam int ADDR_WIDTH  = 5;
   localparam int CSR_WIDTH   = 32;

   // Product, and accumulator with room for five terms plus the rounding bias
   localparam int PROD_WIDTH  = COEFF_WIDTH + SAMPLE_BITS;
   localparam int SUM_WIDTH   = PROD_WIDTH + 3;
   localparam int BIAS_WIDTH  = COEFF_FRAC_BITS + SAMPLE_FRAC_BITS + 1;
   localparam int ACC_WIDTH   = (SUM_WIDTH > BIAS_WIDTH) ? SUM_WIDTH : BIAS_WIDTH + 1;

   typedef enum logic [2:0] {
      REG_FF_COEFF_0 = 3'd0,
      REG_FF_COEFF_1 = 3'd1,
      REG_FF_COEFF_2 = 3'd2,
      REG_FB_COEFF_1 = 3'd3,
      REG_FB_COEFF_2 = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [COEFF_WIDTH-1:0] ff0;
      logic signed [COEFF_WIDTH-1:0] ff1;
      logic signed [COEFF_WIDTH-1:0] ff2;
      logic signed [COEFF_WIDTH-1:0] fb1;
      logic signed [COEFF_WIDTH-1:0] fb2;
   } coeff_set_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x0;
      logic signed [SAMPLE_BITS-1:0] x1;
      logic signed [SAMPLE_BITS-1:0] x2;
      logic signed [SAMPLE_BITS-1:0] y1;
      logic signed [SAMPLE_BITS-1:0] y2;
   } tap_set_type;

endpackage

// ===== hdl/iirdf1_csr.sv =====
module iirdf1_csr
   import iirdf1_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_WIDTH-1:0]  csr_prdata,
   output logic                  csr_pready,
   output coeff_set_type         coeffs
);

   logic signed [COEFF_WIDTH-1:0] coeff_ff [NUM_REGS];
   logic signed [COEFF_WIDTH-1:0] rd_coeff;
   logic [2:0]                    reg_sel;
   logic                          wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[ADDR_WIDTH-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Coefficient registers, low bits of the write data kept
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_FF_COEFF_0: coeff_ff[0] <= csr_pwdata[COEFF_WIDTH-1:0];
            REG_FF_COEFF_1: coeff_ff[1] <= csr_pwdata[COEFF_WIDTH-1:0];
            REG_FF_COEFF_2: coeff_ff[2] <= csr_pwdata[COEFF_WIDTH-1:0];
            REG_FB_COEFF_1: coeff_ff[3] <= csr_pwdata[COEFF_WIDTH-1:0];
            REG_FB_COEFF_2: coeff_ff[4] <= csr_pwdata[COEFF_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Readback, sign-extended to the bus
   always_comb begin
      unique case (reg_sel)
         REG_FF_COEFF_0: rd_coeff = coeff_ff[0];
         REG_FF_COEFF_1: rd_coeff = coeff_ff[1];
         REG_FF_COEFF_2: rd_coeff = coeff_ff[2];
         REG_FB_COEFF_1: rd_coeff = coeff_ff[3];
         REG_FB_COEFF_2: rd_coeff = coeff_ff[4];
         default:        rd_coeff = '0;
      endcase
   end

   assign csr_prdata = CSR_WIDTH'(rd_coeff);

   assign coeffs.ff0 = coeff_ff[0];
   assign coeffs.ff1 = coeff_ff[1];
   assign coeffs.ff2 = coeff_ff[2];
   assign coeffs.fb1 = coeff_ff[3];
   assign coeffs.fb2 = coeff_ff[4];

endmodule

// ===== hdl/iirdf1_mac.sv =====
module iirdf1_mac
   import iirdf1_pkg::*;
(
   input  coeff_set_type                 coeffs,
   input  tap_set_type                   taps,
   output logic signed [SAMPLE_BITS-1:0] y
);

   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
      ACC_WIDTH'(1) << (COEFF_FRAC_BITS + SAMPLE_FRAC_BITS - 1);
   localparam logic signed [ACC_WIDTH-1:0] Y_MAX =
      ACC_WIDTH'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_WIDTH-1:0] Y_MIN =
      ACC_WIDTH'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   logic signed [PROD_WIDTH-1:0] p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;
   logic signed [ACC_WIDTH-1:0]  t_ff1, t_ff2, t_fb2;
   logic signed [ACC_WIDTH-1:0]  acc;
   logic signed [ACC_WIDTH-1:0]  scaled;

   // Five independent products
   assign p_ff0 = coeffs.ff0 * taps.x0;
   assign p_ff1 = coeffs.ff1 * taps.x1;
   assign p_ff2 = coeffs.ff2 * taps.x2;
   assign p_fb1 = coeffs.fb1 * taps.y1;
   assign p_fb2 = coeffs.fb2 * taps.y2;

   // Taps beyond the configured counts drop out
   assign t_ff1 = (FF_TAPS >= 2) ? ACC_WIDTH'(p_ff1) : '0;
   assign t_ff2 = (FF_TAPS >= 3) ? ACC_WIDTH'(p_ff2) : '0;
   assign t_fb2 = (FB_TAPS >= 2) ? ACC_WIDTH'(p_fb2) : '0;

   // Sum, round and drop the coefficient fraction
   assign acc = ACC_WIDTH'(p_ff0) + t_ff1 + t_ff2 - ACC_WIDTH'(p_fb1) - t_fb2 + ROUND_BIAS;
   assign scaled = acc >>> COEFF_FRAC_BITS;

   // Clamp to the sample range
   always_comb begin
      if (scaled > Y_MAX) begin
         y = Y_MAX[SAMPLE_BITS-1:0];
      end else if (scaled < Y_MIN) begin
         y = Y_MIN[SAMPLE_BITS-1:0];
      end else begin
         y = scaled[SAMPLE_BITS-1:0];
      end
   end

endmodule

// ===== hdl/iir_direct_form1_filter_top.sv =====
// Direct form I biquad: y[n] = sat((b0*x[n] + b1*x[n-1] + b2*x[n-2] - a1*y[n-1] - a2*y[n-2]
// + rounding bias) >>> 14), coefficients signed 18 bits with 14 fraction bits, samples
// signed 16 bits. A beat is taken into an input register, the five products are summed,
// rounded and clamped in one pass, and the result lands in the output register together
// with the history update. Sustained rate is one sample per clock while rsp_tready is high.
// The combinational path through the y[n-1] feedback (multiply, five-term add, clamp) sets
// the clock. Coefficients are written through the register port at byte addresses 0, 4,
// 8, 12, 16 (b0, b1, b2, a1, a2); the user must write them only while idle, and the block
// itself does not enforce it.
module iir_direct_form1_filter_top
   import iirdf1_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] sample_in
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [15:0] sample_out
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_WIDTH-1:0]  csr_prdata,
   output logic                  csr_pready
);

   coeff_set_type                 coeffs;
   tap_set_type                   taps;
   logic signed [SAMPLE_BITS-1:0] y_next;

   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff;
   logic signed [SAMPLE_BITS-1:0] x_hist_ff [2];
   logic signed [SAMPLE_BITS-1:0] y_hist_ff [2];
   logic                          advance;

   iirdf1_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coeffs      (coeffs)
   );

   assign taps.x0 = x_ff;
   assign taps.x1 = x_hist_ff[0];
   assign taps.x2 = x_hist_ff[1];
   assign taps.y1 = y_hist_ff[0];
   assign taps.y2 = y_hist_ff[1];

   iirdf1_mac u_mac (
      .coeffs (coeffs),
      .taps   (taps),
      .y      (y_next)
   );

   // Input stage moves on when the output register is free or being drained
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         x_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y_ff <= y_next;
      end
   end

   // Sample histories shift once per finished sample
   always_ff @(posedge clock) begin
      if (reset) begin
         x_hist_ff[0] <= '0;
         x_hist_ff[1] <= '0;
         y_hist_ff[0] <= '0;
         y_hist_ff[1] <= '0;
      end else if (advance) begin
         x_hist_ff[0] <= x_ff;
         x_hist_ff[1] <= x_hist_ff[0];
         y_hist_ff[0] <= y_next;
         y_hist_ff[1] <= y_hist_ff[0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = 16'(y_ff);

`ifndef NO_ASSERTIONS
   // Stall only when both stages hold a beat and the sink is not taking one
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipe");

   // A finished sample always shows up at the output
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result lost on advance");

   // Fed-back output equals the delivered output
   a_feedback_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> (y_hist_ff[0] == y_ff))
      else $error("output history differs from result");

   // Input history takes the sample just processed
   a_input_hist: assert property (@(posedge clock) disable iff (reset)
      advance |=> (x_hist_ff[0] == $past(x_ff)))
      else $error("input history not updated");
`endif

endmodule
